// ===== design/arw_pkg.sv =====
// package for the adaptive roulette wheel selector
// holds payload structs, code enums, reset constants and the sequencer states
// no dependencies
`default_nettype none

package arw_pkg;

    // default number of operators
    localparam int MAX_OPS_DEF = 8;

    // weight format, unsigned q1.15
    localparam int          W_W     = 16;
    localparam logic [15:0] ONE_Q15 = 16'd32768;

    // register reset values
    localparam logic [3:0]  ACTIVE_RST = 4'd8;
    localparam logic [15:0] SMOOTH_RST = 16'd16384;
    localparam logic [15:0] MINW_RST   = 16'd328;

    // configuration port widths
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // command codes
    typedef enum logic [1:0] {
        ACT_SELECT = 2'd0,
        ACT_SCORE  = 2'd1,
        ACT_UPDATE = 2'd2,
        ACT_NONE   = 2'd3
    } act_e;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ACTIVE = 2'd0,
        CFG_SMOOTH = 2'd1,
        CFG_MINW   = 2'd2
    } cfg_idx_e;

    // command payload
    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] random_fraction;
        logic [15:0] score;
    } cmd_t;

    // result payload
    typedef struct packed {
        logic [2:0] chosen_id;
        logic       is_selection;
    } res_t;

    // per operator statistics entry
    typedef struct packed {
        logic [31:0] sum;
        logic [15:0] cnt;
    } stat_t;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEL_RD,
        ST_SEL_ADD,
        ST_SEL_MUL,
        ST_PICK_RD,
        ST_PICK_CMP,
        ST_SC_RD,
        ST_SC_WR,
        ST_UPD_RD,
        ST_UPD_CHK,
        ST_UPD_DIV,
        ST_UPD_M1,
        ST_UPD_M2,
        ST_UPD_CLAMP,
        ST_UPD_WR,
        ST_FINISH
    } state_t;

endpackage

`default_nettype wire

// ===== design/adaptive_roulette_wheel_selector.sv =====
// Adaptive roulette wheel selector, top level.
// Depends on arw_pkg, arw_ram and arw_div.
// Usage: commands enter on cmd (cmd_valid / cmd_stall), one result per command
// leaves on res (res_valid / res_stall). A transfer happens at a clock edge with
// valid high and stall low. cmd_stall is high while a command is being worked.
// Configuration (active count, smoothing, minimum weight) is written through
// cfg_we / cfg_index / cfg_wdata; write it only while the block is idle.
// The block itself does not enforce this. Steps per command:
//   select : a pass summing weights, one multiply, a second pass comparing
//            running sums, all on one memory read port
//   score  : read, saturating add, write
//   update : per operator, a divide by the 32-step serial divider and a blend
//            when it was used, else the minimum weight
//   action code 3: no state change
// The shared 16x32 multiplier serves both select scaling and update blending.
// The result sits in an output register; the next command is accepted while it
// waits. If the receiver stalls and a second result is ready, the sequencer
// holds in its final state until the output register empties.
// Reset: weights read as 1.0, scores and counts as zero through per-entry
// valid bits, so no clearing pass is needed; the block is ready at once.
`default_nettype none

module adaptive_roulette_wheel_selector #(
    parameter int MAX_OPS = arw_pkg::MAX_OPS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cmd_valid,
    output logic                                   cmd_stall,
    input  wire arw_pkg::cmd_t                     cmd,
    output logic                                   res_valid,
    input  wire logic                              res_stall,
    output arw_pkg::res_t                          res,
    input  wire logic                              cfg_we,
    input  wire logic [arw_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [arw_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    import arw_pkg::*;

    localparam int ID_W  = $clog2(MAX_OPS);
    localparam int TOT_W = W_W + ID_W;
    localparam int TGT_W = 16 + TOT_W;
    localparam int ST_W  = $bits(stat_t);
    localparam logic [7:0] MAX8 = 8'(MAX_OPS);

    // configuration registers
    logic [3:0]  active_reg;
    logic [15:0] smooth_reg;
    logic [15:0] minw_reg;

    // sequencer and datapath registers
    state_t            state_reg, state_next;
    logic [ID_W-1:0]   k_reg, k_next;
    logic [ID_W-1:0]   nm1_reg, nm1_next;
    logic [ID_W-1:0]   last_reg, last_next;
    logic              sel_reg, sel_next;
    logic [15:0]       rnd_reg, rnd_next;
    logic [15:0]       score_reg, score_next;
    logic [TOT_W-1:0]  total_reg, total_next;
    logic [TOT_W-1:0]  run_reg, run_next;
    logic [TGT_W-1:0]  target_reg, target_next;
    logic [47:0]       acc_reg, acc_next;
    logic [15:0]       old_reg, old_next;
    logic [15:0]       wnew_reg, wnew_next;
    logic [MAX_OPS-1:0] wvld_reg, wvld_next;
    logic [MAX_OPS-1:0] svld_reg, svld_next;
    logic              rd_wvld_reg, rd_svld_reg;
    logic              res_valid_reg, res_valid_next;
    res_t              res_reg, res_next;

    // memory ports
    logic [ID_W-1:0] raddr;
    logic            w_we, s_we;
    logic [15:0]     w_rdata;
    stat_t           s_rdata;
    stat_t           s_wdata;
    logic [15:0]     w_eff;
    stat_t           st_eff;

    // shared multiplier
    logic [15:0] mul_a;
    logic [31:0] mul_b;
    logic [47:0] mul_p;

    // divider
    logic        div_start;
    logic        div_done;
    logic [31:0] div_quo;

    // misc combinational values
    logic [7:0]       n8;
    logic [ID_W-1:0]  nm1_c;
    logic [15:0]      s_eff;
    logic [TOT_W-1:0] run_sum;
    logic [32:0]      sum33;
    logic [32:0]      w33;
    logic [15:0]      wsat;
    logic [ID_W+2:0]  last_ext;
    logic             res_load;

    // configuration write port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= ACTIVE_RST;
            smooth_reg <= SMOOTH_RST;
            minw_reg   <= MINW_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ACTIVE: active_reg <= cfg_wdata[3:0];
                CFG_SMOOTH: smooth_reg <= cfg_wdata;
                CFG_MINW:   minw_reg   <= cfg_wdata;
                default:    ;
            endcase
        end
    end

    // clamp the active count to 1..MAX_OPS, kept as last index
    always_comb
    begin
        n8 = {4'b0, active_reg};
        if (n8 == 8'd0)
        begin
            n8 = 8'd1;
        end
        else if (n8 > MAX8)
        begin
            n8 = MAX8;
        end
    end
    assign nm1_c = ID_W'(n8 - 8'd1);

    // smoothing above one acts as one
    assign s_eff = (smooth_reg > ONE_Q15) ? ONE_Q15 : smooth_reg;

    // memories; entries not yet written read as their reset value
    assign raddr = (state_reg == ST_SC_RD) ? last_reg : k_reg;

    arw_ram #(
        .WIDTH (W_W),
        .DEPTH (MAX_OPS)
    ) u_weight_ram (
        .clk   (clk),
        .we    (w_we),
        .waddr (k_reg),
        .wdata (wnew_reg),
        .raddr (raddr),
        .rdata (w_rdata)
    );

    arw_ram #(
        .WIDTH (ST_W),
        .DEPTH (MAX_OPS)
    ) u_stat_ram (
        .clk   (clk),
        .we    (s_we),
        .waddr (last_reg),
        .wdata (s_wdata),
        .raddr (raddr),
        .rdata (s_rdata)
    );

    assign w_eff  = rd_wvld_reg ? w_rdata : ONE_Q15;
    assign st_eff = rd_svld_reg ? s_rdata : '0;

    // saturating score accumulation
    assign sum33         = {1'b0, st_eff.sum} + {17'b0, score_reg};
    assign s_wdata.sum   = sum33[32] ? 32'hFFFF_FFFF : sum33[31:0];
    assign s_wdata.cnt   = (st_eff.cnt == 16'hFFFF) ? st_eff.cnt : st_eff.cnt + 16'd1;

    // divider for the average score
    arw_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (st_eff.sum),
        .divisor  (st_eff.cnt),
        .done     (div_done),
        .quotient (div_quo)
    );

    // multiplier operand selection
    always_comb
    begin
        unique case (state_reg)
            ST_SEL_MUL:
            begin
                mul_a = rnd_reg;
                mul_b = 32'(total_reg);
            end
            ST_UPD_M2:
            begin
                mul_a = ONE_Q15 - s_eff;
                mul_b = {16'b0, old_reg};
            end
            default:
            begin
                mul_a = s_eff;
                mul_b = div_quo;
            end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    // running sum for the pick pass
    assign run_sum = run_reg + TOT_W'(w_eff);

    // blended weight, saturated then clamped below
    assign w33  = acc_reg[47:15];
    assign wsat = (|w33[32:16]) ? 16'hFFFF : w33[15:0];

    // result id is the low three bits of the last choice
    assign last_ext = {3'b0, last_reg};

    // sequencer: next state and datapath controls
    always_comb
    begin
        state_next  = state_reg;
        k_next      = k_reg;
        nm1_next    = nm1_reg;
        last_next   = last_reg;
        sel_next    = sel_reg;
        rnd_next    = rnd_reg;
        score_next  = score_reg;
        total_next  = total_reg;
        run_next    = run_reg;
        target_next = target_reg;
        acc_next    = acc_reg;
        old_next    = old_reg;
        wnew_next   = wnew_reg;
        wvld_next   = wvld_reg;
        svld_next   = svld_reg;
        w_we        = 1'b0;
        s_we        = 1'b0;
        div_start   = 1'b0;
        res_load    = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    rnd_next   = cmd.random_fraction;
                    score_next = cmd.score;
                    nm1_next   = nm1_c;
                    k_next     = '0;
                    total_next = '0;
                    run_next   = '0;
                    sel_next   = 1'b0;
                    unique case (cmd.action)
                        ACT_SELECT: state_next = ST_SEL_RD;
                        ACT_SCORE:  state_next = ST_SC_RD;
                        ACT_UPDATE: state_next = ST_UPD_RD;
                        default:    state_next = ST_FINISH;
                    endcase
                end
            end

            // first pass: total of active weights
            ST_SEL_RD:
            begin
                state_next = ST_SEL_ADD;
            end
            ST_SEL_ADD:
            begin
                total_next = total_reg + TOT_W'(w_eff);
                if (k_reg == nm1_reg)
                begin
                    k_next     = '0;
                    state_next = ST_SEL_MUL;
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = ST_SEL_RD;
                end
            end
            ST_SEL_MUL:
            begin
                target_next = mul_p[TGT_W-1:0];
                state_next  = ST_PICK_RD;
            end

            // second pass: first running sum reaching the target
            ST_PICK_RD:
            begin
                state_next = ST_PICK_CMP;
            end
            ST_PICK_CMP:
            begin
                if ((target_reg <= {run_sum, 16'b0}) || (k_reg == nm1_reg))
                begin
                    last_next  = k_reg;
                    sel_next   = 1'b1;
                    state_next = ST_FINISH;
                end
                else
                begin
                    run_next   = run_sum;
                    k_next     = k_reg + 1'b1;
                    state_next = ST_PICK_RD;
                end
            end

            // score accumulation on the last choice
            ST_SC_RD:
            begin
                state_next = ST_SC_WR;
            end
            ST_SC_WR:
            begin
                s_we                = 1'b1;
                svld_next[last_reg] = 1'b1;
                state_next          = ST_FINISH;
            end

            // weight update, one operator per round
            ST_UPD_RD:
            begin
                state_next = ST_UPD_CHK;
            end
            ST_UPD_CHK:
            begin
                old_next = w_eff;
                if (st_eff.cnt == 16'd0)
                begin
                    wnew_next  = minw_reg;
                    state_next = ST_UPD_WR;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = ST_UPD_DIV;
                end
            end
            ST_UPD_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_UPD_M1;
                end
            end
            ST_UPD_M1:
            begin
                acc_next   = mul_p;
                state_next = ST_UPD_M2;
            end
            ST_UPD_M2:
            begin
                acc_next   = acc_reg + mul_p;
                state_next = ST_UPD_CLAMP;
            end
            ST_UPD_CLAMP:
            begin
                wnew_next  = (wsat < minw_reg) ? minw_reg : wsat;
                state_next = ST_UPD_WR;
            end
            ST_UPD_WR:
            begin
                w_we             = 1'b1;
                wvld_next[k_reg] = 1'b1;
                svld_next[k_reg] = 1'b0;
                if (k_reg == nm1_reg)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = ST_UPD_RD;
                end
            end

            // hand the result to the output register
            ST_FINISH:
            begin
                if (!res_valid_reg || !res_stall)
                begin
                    res_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output register
    always_comb
    begin
        res_next = res_reg;
        if (res_load)
        begin
            res_next.chosen_id    = last_ext[2:0];
            res_next.is_selection = sel_reg;
        end
    end

    always_comb
    begin
        priority if (res_load)
        begin
            res_valid_next = 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            last_reg      <= '0;
            wvld_reg      <= '0;
            svld_reg      <= '0;
            res_valid_reg <= 1'b0;
            rd_wvld_reg   <= 1'b0;
            rd_svld_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            last_reg      <= last_next;
            wvld_reg      <= wvld_next;
            svld_reg      <= svld_next;
            res_valid_reg <= res_valid_next;
            rd_wvld_reg   <= wvld_reg[raddr];
            rd_svld_reg   <= svld_reg[raddr];
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        k_reg      <= k_next;
        nm1_reg    <= nm1_next;
        sel_reg    <= sel_next;
        rnd_reg    <= rnd_next;
        score_reg  <= score_next;
        total_reg  <= total_next;
        run_reg    <= run_next;
        target_reg <= target_next;
        acc_reg    <= acc_next;
        old_reg    <= old_next;
        wnew_reg   <= wnew_next;
        res_reg    <= res_next;
    end

    assign cmd_stall = (state_reg != ST_IDLE);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

`default_nettype wire

// ===== design/arw_ram.sv =====
// simple dual port memory, one write port and one registered read port
// no package dependencies
`default_nettype none

module arw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== design/arw_div.sv =====
// radix-2 restoring divider, 32-bit dividend by 16-bit divisor, one bit per cycle
// no package dependencies
`default_nettype none

module arw_div (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [31:0] dividend,
    input  wire logic [15:0] divisor,
    output logic             done,
    output logic [31:0]      quotient
);

    localparam int          STEPS = 32;
    localparam int          CNT_W = $clog2(STEPS);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(STEPS - 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [15:0]      rem_reg, rem_next;
    logic [31:0]      quo_reg, quo_next;
    logic [15:0]      dsr_reg, dsr_next;
    logic [16:0]      trial;
    logic [16:0]      diff;
    logic             fits;

    // one trial subtraction per cycle
    assign trial = {rem_reg, quo_reg[31]};
    assign diff  = trial - {1'b0, dsr_reg};
    assign fits  = trial >= {1'b0, dsr_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[15:0] : trial[15:0];
            quo_next = {quo_reg[30:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// ===== design/arw_checker.sv =====
// port level checks for the adaptive roulette wheel selector, bound to the top
// depends on arw_pkg
`default_nettype none

module arw_checker (
    input wire logic          clk,
    input wire logic          rst_n,
    input wire logic          cmd_valid,
    input wire logic          cmd_stall,
    input wire logic          res_valid,
    input wire logic          res_stall,
    input wire arw_pkg::res_t res
);

    import arw_pkg::*;

    // a stalled result stays and holds its payload
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_stall) |=> (res_valid && $stable(res)))
        else $error("stalled result changed or dropped");

    // a command transfer makes the block busy in the next cycle
    a_busy_after_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && !cmd_stall) |=> cmd_stall)
        else $error("block not busy after command transfer");

    // a new result only appears at the end of command work
    a_res_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(cmd_stall))
        else $error("result appeared without command work");

    // finishing a command leaves its result in the output register
    a_done_has_res: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(cmd_stall) |-> res_valid)
        else $error("command finished without a result");

endmodule

bind adaptive_roulette_wheel_selector arw_checker u_arw_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
);

`default_nettype wire

// ===== tb/roulette_checker.sv =====
// checker for the adaptive roulette wheel selector: keeps its own copy of weights,
// score sums, use counts and registers, predicts every result and compares it
// depends on arw_pkg
module roulette_checker #(
    parameter int MAX_OPS = arw_pkg::MAX_OPS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cmd_valid,
    input  logic                              cmd_stall,
    input  arw_pkg::cmd_t                     cmd,
    input  logic                              res_valid,
    input  logic                              res_stall,
    input  arw_pkg::res_t                     res,
    input  logic                              cfg_we,
    input  logic [arw_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [arw_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    output int                                fail_count,
    output int                                pending,
    output int                                checked
);
    timeunit 1ns;
    timeprecision 1ps;

    import arw_pkg::*;

    // mirrored block state
    logic [15:0] weight_q    [MAX_OPS];
    logic [31:0] score_total [MAX_OPS];
    logic [15:0] use_tally   [MAX_OPS];
    logic [2:0]  last_pick;
    logic [3:0]  active_reg;
    logic [15:0] smooth_reg;
    logic [15:0] floor_reg;

    // predicted results, oldest first
    res_t        expected_picks [$];
    res_t        oldest;

    // operators taking part, out of range counts folded in
    function automatic int unsigned live_ops();
        int unsigned n;
        n = active_reg;
        if (n < 1)
            n = 1;
        if (n > MAX_OPS)
            n = MAX_OPS;
        return n;
    endfunction

    // first operator whose running weight reaches fraction * total, exact compare
    function automatic logic [2:0] spin_wheel(input logic [15:0] frac);
        int unsigned n;
        logic [63:0] total;
        logic [63:0] run;
        logic [63:0] target;
        logic [2:0]  pick;
        logic        found;
        n = live_ops();
        total = '0;
        run = '0;
        found = 1'b0;
        pick = 3'(n - 1);
        for (int k = 0; k < n; k++)
            total = total + 64'(weight_q[k]);
        target = 64'(frac) * total;
        for (int k = 0; k < n; k++)
        begin
            run = run + 64'(weight_q[k]);
            if (!found && target <= (run << 16))
            begin
                pick = 3'(k);
                found = 1'b1;
            end
        end
        return pick;
    endfunction

    // saturating score sum and use count of the remembered operator
    function automatic void credit_score(input logic [15:0] sc);
        logic [32:0] sum;
        sum = {1'b0, score_total[last_pick]} + 33'(sc);
        score_total[last_pick] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
        if (use_tally[last_pick] != 16'hFFFF)
            use_tally[last_pick] = use_tally[last_pick] + 16'd1;
    endfunction

    // blend average score into each active weight, clamp, clear statistics
    function automatic void reweight();
        int unsigned n;
        logic [63:0] s;
        logic [63:0] avg;
        logic [63:0] w;
        n = live_ops();
        s = (smooth_reg > ONE_Q15) ? 64'(ONE_Q15) : 64'(smooth_reg);
        for (int k = 0; k < n; k++)
        begin
            if (use_tally[k] != 16'd0)
            begin
                avg = 64'(score_total[k]) / 64'(use_tally[k]);
                w = (s * avg + (64'(ONE_Q15) - s) * 64'(weight_q[k])) >> 15;
                if (w > 64'hFFFF)
                    w = 64'hFFFF;
                if (w < 64'(floor_reg))
                    w = 64'(floor_reg);
            end
            else
                w = 64'(floor_reg);
            weight_q[k] = w[15:0];
            score_total[k] = '0;
            use_tally[k] = '0;
        end
    endfunction

    // apply one command to the mirror and return the result it should give
    function automatic res_t predict_result(input cmd_t c);
        res_t r;
        r.is_selection = 1'b0;
        case (act_e'(c.action))
            ACT_SELECT:
            begin
                last_pick = spin_wheel(c.random_fraction);
                r.is_selection = 1'b1;
            end
            ACT_SCORE:
                credit_score(c.score);
            ACT_UPDATE:
                reweight();
            default:
                ;
        endcase
        r.chosen_id = last_pick;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < MAX_OPS; k++)
            begin
                weight_q[k] = ONE_Q15;
                score_total[k] = '0;
                use_tally[k] = '0;
            end
            last_pick = '0;
            active_reg = ACTIVE_RST;
            smooth_reg = SMOOTH_RST;
            floor_reg = MINW_RST;
            expected_picks.delete();
            fail_count = 0;
            checked = 0;
            pending = 0;
        end
        else
        begin
            // result transfer, compared with the oldest prediction
            if (res_valid && !res_stall)
            begin
                if (expected_picks.size() == 0)
                begin
                    $error("result transfer with nothing expected: chosen_id %0d is_selection %0d",
                           res.chosen_id, res.is_selection);
                    fail_count++;
                end
                else
                begin
                    oldest = expected_picks.pop_front();
                    checked++;
                    if (res.chosen_id !== oldest.chosen_id)
                    begin
                        $error("chosen_id: expected %0d, got %0d",
                               oldest.chosen_id, res.chosen_id);
                        fail_count++;
                    end
                    if (res.is_selection !== oldest.is_selection)
                    begin
                        $error("is_selection: expected %0d, got %0d",
                               oldest.is_selection, res.is_selection);
                        fail_count++;
                    end
                end
            end

            // command transfer
            if (cmd_valid && !cmd_stall)
                expected_picks.push_back(predict_result(cmd));

            // register write
            if (cfg_we)
            begin
                case (cfg_idx_e'(cfg_index))
                    CFG_ACTIVE: active_reg = cfg_wdata[3:0];
                    CFG_SMOOTH: smooth_reg = cfg_wdata;
                    CFG_MINW:   floor_reg = cfg_wdata;
                    default:    ;
                endcase
            end

            pending = expected_picks.size();
        end
    end

endmodule

// ===== tb/testbench.sv =====
// top of the testbench for the adaptive roulette wheel selector: clock, reset,
// command and configuration stimulus, receiver stalls and the final verdict
// depends on arw_pkg, roulette_checker and the selector rtl
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import arw_pkg::*;

    localparam int RUN_LIMIT    = 4_000_000;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 190;
    localparam int BURST_SCORES = 40;
    localparam int HOLD_CYCLES  = 300;
    localparam int TAIL_CYCLES  = 400;

    logic                  clk;
    logic                  rst_n;
    logic                  cmd_valid;
    logic                  cmd_stall;
    cmd_t                  cmd;
    logic                  res_valid;
    logic                  res_stall;
    res_t                  res;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    int fail_count;
    int pending;
    int checked;

    int send_idle_pct = 0;
    int stall_pct = 0;
    int holds_asked = 0;
    int holds_served = 0;
    int cycles = 0;
    int settings_applied = 0;
    int sent_by_action [4] = '{0, 0, 0, 0};

    adaptive_roulette_wheel_selector dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    roulette_checker chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_stall  (cmd_stall),
        .cmd        (cmd),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res        (res),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .fail_count (fail_count),
        .pending    (pending),
        .checked    (checked)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        while (cycles < RUN_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("run stopped at the cycle limit with %0d results outstanding", pending);
        $display("CHECKS FAILED");
        $finish;
    end

    // receiver: random stalls, plus long hold-offs on request
    initial
    begin
        res_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (holds_served != holds_asked)
            begin
                holds_served++;
                res_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end
            else
                res_stall <= (stall_pct > 0) && ($urandom_range(0, 99) < stall_pct);
        end
    end

    // random fraction with the extremes weighted up
    function automatic logic [15:0] rand_fraction();
        case ($urandom_range(0, 9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'($urandom_range(0, 15));
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    // score mostly within 0..1.0, sometimes above
    function automatic logic [15:0] rand_score();
        case ($urandom_range(0, 9))
            0:       return 16'd0;
            1:       return ONE_Q15;
            2, 3:    return 16'($urandom_range(0, 65535));
            default: return 16'($urandom_range(0, 32768));
        endcase
    endfunction

    // one command transfer, starting and ending at a falling edge
    task automatic send_cmd(input act_e act, input logic [15:0] frac, input logic [15:0] sc);
        cmd_t c;
        c.action = act;
        c.random_fraction = frac;
        c.score = sc;
        if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct)
        begin
            cmd_valid <= 1'b0;
            cmd <= cmd_t'($urandom);
            do
                @(negedge clk);
            while ($urandom_range(0, 99) < send_idle_pct);
        end
        cmd <= c;
        cmd_valid <= 1'b1;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        @(negedge clk);
        sent_by_action[act]++;
    endtask

    // stop offering and wait until every result has been taken
    task automatic drain_results();
        cmd_valid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
    endtask

    task automatic write_cfg(input cfg_idx_e idx, input logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        cfg_wdata <= 16'($urandom);
        @(negedge clk);
    endtask

    task automatic set_config(input logic [3:0] ops, input logic [15:0] smooth,
                              input logic [15:0] floor_w);
        write_cfg(CFG_ACTIVE, {12'd0, ops});
        write_cfg(CFG_SMOOTH, smooth);
        write_cfg(CFG_MINW, floor_w);
        settings_applied++;
    endtask

    // search-loop traffic: mostly select followed by scores, with updates and noise
    task automatic run_search_loop(input int items);
        int sent;
        int roll;
        int reps;
        sent = 0;
        while (sent < items)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 64)
            begin
                reps = $urandom_range(1, 2);
                send_cmd(ACT_SELECT, rand_fraction(), rand_score());
                repeat (reps) send_cmd(ACT_SCORE, rand_fraction(), rand_score());
                sent += 1 + reps;
            end
            else if (roll < 72)
            begin
                send_cmd(ACT_UPDATE, rand_fraction(), rand_score());
                sent++;
            end
            else if (roll < 80)
            begin
                reps = $urandom_range(3, 8);
                repeat (reps) send_cmd(ACT_SCORE, rand_fraction(), rand_score());
                sent += reps;
            end
            else if (roll < 88)
            begin
                send_cmd(ACT_SELECT, rand_fraction(), rand_score());
                sent++;
            end
            else if (roll < 94)
            begin
                send_cmd(ACT_SCORE, rand_fraction(), rand_score());
                sent++;
            end
            else
            begin
                send_cmd(ACT_NONE, rand_fraction(), rand_score());
                sent++;
            end
        end
    endtask

    // stimulus and verdict
    initial
    begin
        rst_n = 1'b0;
        cmd_valid = 1'b0;
        cmd = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset weights: ends of the fraction range, scores at and above one
        send_cmd(ACT_SELECT, 16'h0000, 16'h0000);
        send_cmd(ACT_SELECT, 16'hFFFF, 16'hFFFF);
        send_cmd(ACT_SCORE, 16'h0000, ONE_Q15);
        send_cmd(ACT_SCORE, 16'hFFFF, 16'hFFFF);
        send_cmd(ACT_SCORE, 16'h1234, 16'h0000);
        send_cmd(ACT_NONE, 16'hFFFF, 16'hFFFF);
        send_cmd(ACT_UPDATE, 16'h0000, 16'h0000);
        send_cmd(ACT_SELECT, 16'h8000, 16'h0000);
        send_cmd(ACT_SELECT, 16'h0001, 16'h0000);
        send_cmd(ACT_SELECT, 16'hFFFF, 16'h0000);

        // remembered operator outside the active set keeps its statistics
        drain_results();
        set_config(4'd2, 16'd16384, 16'd328);
        send_cmd(ACT_SCORE, 16'h0000, 16'd1000);
        send_cmd(ACT_UPDATE, 16'h0000, 16'h0000);
        send_cmd(ACT_SELECT, rand_fraction(), 16'h0000);

        // count above the operator limit, zero floor, full smoothing, all weights zero
        drain_results();
        set_config(4'd15, 16'd32768, 16'd0);
        send_cmd(ACT_UPDATE, 16'h0000, 16'h0000);
        send_cmd(ACT_SELECT, 16'h0000, 16'h0000);
        send_cmd(ACT_SELECT, 16'hFFFF, 16'h0000);
        send_cmd(ACT_UPDATE, 16'h0000, 16'h0000);
        send_cmd(ACT_SELECT, 16'hFFFF, 16'h0000);

        // zero count, smoothing above one, floor at the top
        drain_results();
        set_config(4'd0, 16'd65535, 16'd65535);
        send_cmd(ACT_SCORE, 16'h0000, 16'd12345);
        send_cmd(ACT_UPDATE, 16'h0000, 16'h0000);
        send_cmd(ACT_SELECT, 16'd40000, 16'h0000);

        // run of top scores on one operator, average well above one
        drain_results();
        set_config(4'd8, 16'd32768, 16'd328);
        send_cmd(ACT_SELECT, 16'h0000, 16'h0000);
        repeat (BURST_SCORES) send_cmd(ACT_SCORE, rand_fraction(), 16'hFFFF);
        send_cmd(ACT_UPDATE, 16'h0000, 16'h0000);
        send_cmd(ACT_SELECT, rand_fraction(), 16'h0000);

        // random phases over register settings and idling patterns
        for (int p = 0; p < PHASES; p++)
        begin
            drain_results();
            case (p)
                0: set_config(4'd8, 16'd16384, 16'd328);
                1: set_config(4'd1, 16'd32768, 16'd0);
                2: set_config(4'd3, 16'd0, 16'd65535);
                3: set_config(4'd0, 16'd65535, 16'd100);
                4: set_config(4'd15, 16'd8192, 16'd1000);
                5: set_config(4'($urandom_range(2, 7)), 16'($urandom_range(0, 32768)),
                              16'($urandom_range(0, 4000)));
                6: set_config(4'd2, 16'd1, 16'd40000);
                default: set_config(4'd8, 16'd32767, 16'd0);
            endcase
            case (p % 4)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct = 0;
                    holds_asked++;
                end
                1:
                begin
                    send_idle_pct = 70;
                    stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct = 70;
                end
                default:
                begin
                    send_idle_pct = 36;
                    stall_pct = 36;
                end
            endcase
            run_search_loop(PHASE_ITEMS);
        end

        drain_results();
        stall_pct = 0;
        repeat (TAIL_CYCLES) @(negedge clk);

        $display("covered %0d commands: %0d select, %0d score, %0d update, %0d unused code",
                 sent_by_action[0] + sent_by_action[1] + sent_by_action[2] + sent_by_action[3],
                 sent_by_action[ACT_SELECT], sent_by_action[ACT_SCORE],
                 sent_by_action[ACT_UPDATE], sent_by_action[ACT_NONE]);
        $display("%0d results compared over %0d register settings and four idling patterns",
                 checked, settings_applied);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
design/arw_pkg.sv
design/arw_ram.sv
design/arw_div.sv
design/adaptive_roulette_wheel_selector.sv
design/arw_checker.sv
tb/roulette_checker.sv
tb/testbench.sv
